// ----- rtl/core/rpn_pkg.sv -----
// Shared types and codes for the postfix expression evaluator.
`default_nettype none

package rpn_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [DATA_W-1:0]        word_t;
  typedef logic signed [DATA_W-1:0] sword_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam cmd_t CMD_PUSH  = 3'd0;
  localparam cmd_t CMD_ADD   = 3'd1;
  localparam cmd_t CMD_SUB   = 3'd2;
  localparam cmd_t CMD_MUL   = 3'd3;
  localparam cmd_t CMD_DIV   = 3'd4;
  localparam cmd_t CMD_CLEAR = 3'd5;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_DIVZERO = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/rpn_stack_ram.sv -----
// Operand stack memory: one write port, one read port with registered data.
`default_nettype none

module rpn_stack_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire rpn_pkg::word_t wdata,
  input  wire logic [AW-1:0]  raddr,
  output rpn_pkg::word_t      rdata
);
  import rpn_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpn_divider.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rpn_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire rpn_pkg::word_t dividend,
  input  wire rpn_pkg::word_t divisor,
  output logic                done,
  output rpn_pkg::word_t      quotient
);
  import rpn_pkg::*;

  localparam int CW = $clog2(DATA_W);
  localparam logic [CW-1:0] LAST = CW'(DATA_W - 1);

  typedef enum logic [1:0] {D_IDLE, D_STEP, D_FIX} dstate_t;

  dstate_t         state;
  logic [CW-1:0]   cnt;
  word_t           rem;
  word_t           quo;
  word_t           dvsr;
  logic            neg;
  logic [DATA_W:0] shifted;
  logic [DATA_W:0] trial;

  // restoring step on magnitudes
  assign shifted = {rem, quo[DATA_W-1]};
  assign trial   = shifted - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_FIX);
      unique case (state)
        D_IDLE: begin
          if (start) begin
            quo   <= dividend[DATA_W-1] ? ('0 - dividend) : dividend;
            dvsr  <= divisor[DATA_W-1] ? ('0 - divisor) : divisor;
            neg   <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem   <= '0;
            cnt   <= '0;
            state <= D_STEP;
          end
        end
        D_STEP: begin
          if (!trial[DATA_W]) begin
            rem <= trial[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b1};
          end else begin
            rem <= shifted[DATA_W-1:0];
            quo <= {quo[DATA_W-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == LAST) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quotient <= neg ? ('0 - quo) : quo;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/postfix_expression_evaluator.sv -----
// Push, clear and unused codes are answered in their accept cycle; add/sub commit from S_LOAD,
// multiply from S_MUL and divide from S_DIV. A divide by zero commits at once from S_LOAD;
// otherwise the divider sets the cost, one quotient bit per cycle over 32 steps plus load,
// sign fix and commit. Throughput: one token at a time; start is taken whenever busy is low,
// so a divide holds busy until its quotient commits, and the next token waits for that.
// Each result beat shows on done for exactly one cycle; the receiver cannot stall.
// Synchronous active-high reset empties the stack; stack memory contents are left as is.
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire rpn_pkg::cmd_t                  cmd,
  input  wire rpn_pkg::sword_t                operand_value,
  output logic                                done,
  output rpn_pkg::sword_t                     top_value,
  output logic [rpn_pkg::DEPTH_W-1:0]         stack_depth,
  output rpn_pkg::status_t                    status
);
  import rpn_pkg::*;

  // address and pointer widths; pointer must hold STACK_DEPTH itself
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam logic [PW-1:0] FULL_LEVEL = PW'(STACK_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_MUL, S_DIV} state_t;

  state_t        state;
  logic [PW-1:0] sp;          // entries held
  word_t         top_q;       // cached top entry, valid when sp != 0
  cmd_t          cmd_q;
  word_t         right_q;     // right operand (old top or 0)
  logic          missing_q;   // fewer than two operands
  logic [PW-1:0] base_q;      // pointer after the pops
  word_t         prod_q;

  logic          accept;
  logic          quick_done;  // token answered in its accept cycle
  logic [PW-1:0] sp_less2;
  word_t         rd_data;
  word_t         left_op;
  logic          commit;
  word_t         res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic          div_start;
  logic          div_done;
  word_t         div_quot;
  logic          div_by_zero;

  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign quick_done = accept && ((cmd < CMD_ADD) || (cmd > CMD_DIV));
  assign sp_less2   = sp - PW'(2);

  // left operand comes from memory in the cycle after the read is issued
  assign left_op     = missing_q ? '0 : rd_data;
  assign div_by_zero = (right_q == '0);
  assign div_start   = (state == S_LOAD) && (cmd_q == CMD_DIV) && !div_by_zero;

  // Arithmetic commit: result written at base_q, becomes new top.
  always_comb begin
    commit = 1'b0;
    res    = '0;
    unique case (state)
      S_IDLE: begin
        commit = 1'b0;
      end
      S_LOAD: begin
        if (cmd_q == CMD_ADD) begin
          commit = 1'b1;
          res    = left_op + right_q;
        end else if (cmd_q == CMD_SUB) begin
          commit = 1'b1;
          res    = left_op - right_q;
        end else if ((cmd_q == CMD_DIV) && div_by_zero) begin
          commit = 1'b1;
          res    = '0;
        end
      end
      S_MUL: begin
        commit = 1'b1;
        res    = prod_q;
      end
      S_DIV: begin
        commit = div_done;
        res    = div_quot;
      end
      default: commit = 1'b0;
    endcase
  end

  // Single write port: a push in the accept cycle, or an arithmetic commit.
  // The operand read is taken in an arithmetic token's accept cycle, when nothing is written, so no forwarding.
  assign mem_we    = (accept && (cmd == CMD_PUSH) && (sp < FULL_LEVEL)) || commit;
  assign mem_waddr = commit ? base_q[AW-1:0] : sp[AW-1:0];
  assign mem_wdata = commit ? res : word_t'(operand_value);

  rpn_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (sp_less2[AW-1:0]),
    .rdata (rd_data)
  );

  rpn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (left_op),
    .divisor  (right_q),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= commit || quick_done;
      // commit only happens outside S_IDLE and ends the token
      if (commit) begin
        sp          <= base_q + PW'(1);
        top_q       <= res;
        top_value   <= res;
        stack_depth <= DEPTH_W'(base_q + PW'(1));
        if (missing_q) begin
          status <= ST_MISSING;
        end else if ((cmd_q == CMD_DIV) && div_by_zero) begin
          status <= ST_DIVZERO;
        end else begin
          status <= ST_OK;
        end
        state <= S_IDLE;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (start) begin
              cmd_q <= cmd;
              unique case (cmd) inside
                CMD_PUSH: begin
                  if (sp < FULL_LEVEL) begin
                    sp          <= sp + PW'(1);
                    top_q       <= operand_value;
                    top_value   <= operand_value;
                    stack_depth <= DEPTH_W'(sp + PW'(1));
                    status      <= ST_OK;
                  end else begin
                    // full: dropped, stack unchanged
                    top_value   <= top_q;
                    stack_depth <= DEPTH_W'(sp);
                    status      <= ST_FULL;
                  end
                end
                [CMD_ADD:CMD_DIV]: begin
                  missing_q <= (sp < PW'(2));
                  right_q   <= (sp != '0) ? top_q : '0;
                  base_q    <= (sp < PW'(2)) ? '0 : sp_less2;
                  state     <= S_LOAD;
                end
                CMD_CLEAR: begin
                  sp          <= '0;
                  top_value   <= '0;
                  stack_depth <= '0;
                  status      <= ST_OK;
                end
                default: begin
                  // unused codes: report current state
                  top_value   <= (sp != '0) ? top_q : '0;
                  stack_depth <= DEPTH_W'(sp);
                  status      <= ST_OK;
                end
              endcase
            end
          end
          S_LOAD: begin
            if (cmd_q == CMD_MUL) begin
              prod_q <= left_op * right_q;
              state  <= S_MUL;
            end else if (div_start) begin
              state <= S_DIV;
            end
          end
          S_MUL: begin
            state <= S_MUL;
          end
          S_DIV: begin
            state <= S_DIV;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= FULL_LEVEL)
    else $error("stack pointer beyond depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result beat while sequencer busy");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (right_q != '0))
    else $error("divider started with zero divisor");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL)) |-> (sp == FULL_LEVEL))
    else $error("full status on a stack that is not full");

  a_divzero_top: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_DIVZERO)) |-> (top_value == '0))
    else $error("divide by zero left a nonzero top");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_postfix_expression_evaluator.sv -----
// Self-checking testbench for the postfix expression evaluator: directed tokens, then random.
`default_nettype none

module tb_postfix_expression_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  import rpn_pkg::*;

  localparam int STACK_DEPTH = 64;
  // Cycle budget: ~1300 tokens, divides the slowest, plus sender gaps, taken several times over.
  localparam int CYCLE_LIMIT = 400000;
  // Drain tail after the last result: longer than one divide.
  localparam int TAIL_CYCLES = 60;

  // Codes 6 and 7 decode to nothing; they only report the current top and depth.
  localparam cmd_t CMD_SPARE_A = 3'd6;
  localparam cmd_t CMD_SPARE_B = 3'd7;

  localparam word_t WORD_MIN = 32'h8000_0000;
  localparam word_t WORD_MAX = 32'h7FFF_FFFF;
  localparam word_t WORD_M1  = 32'hFFFF_FFFF;

  typedef struct {
    word_t                top;
    logic [DEPTH_W-1:0]   depth;
    status_t              st;
  } stack_report_t;

  // Tracks the operand stack and queues the report each accepted token should produce.
  class stack_tracker;
    word_t         stack_mem [STACK_DEPTH];
    int unsigned   sp;
    stack_report_t pending_reports [$];
    int            errors;

    function void note_token(cmd_t c, word_t v);
      word_t         rhs, lhs, res, mag_l, mag_r, quo;
      bit            has_r, has_l;
      status_t       st;
      stack_report_t rep;
      st = ST_OK;
      case (c)
        CMD_PUSH: begin
          if (sp < STACK_DEPTH) begin
            stack_mem[sp] = v;
            sp++;
          end else begin
            st = ST_FULL;
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
          // top of stack is the right operand; a missing entry reads as zero
          has_r = (sp > 0);
          rhs   = has_r ? stack_mem[sp-1] : '0;
          if (has_r) sp--;
          has_l = (sp > 0);
          lhs   = has_l ? stack_mem[sp-1] : '0;
          if (has_l) sp--;
          if (!(has_r && has_l)) st = ST_MISSING;
          case (c)
            CMD_ADD: res = lhs + rhs;
            CMD_SUB: res = lhs - rhs;
            CMD_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                res = '0;
                if (st == ST_OK) st = ST_DIVZERO;
              end else begin
                // magnitude divide, then sign: truncates toward zero, MIN / -1 wraps
                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                quo   = mag_l / mag_r;
                res   = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
              end
            end
          endcase
          stack_mem[sp] = res;
          sp++;
        end
        CMD_CLEAR: sp = 0;
        default: ;
      endcase
      rep.top   = (sp > 0) ? stack_mem[sp-1] : '0;
      rep.depth = sp[DEPTH_W-1:0];
      rep.st    = st;
      pending_reports.push_back(rep);
    endfunction

    function void check_report(word_t top, logic [DEPTH_W-1:0] depth, status_t st);
      stack_report_t exp_rep;
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing expected: top_value %0d stack_depth %0d status %0d",
               $signed(top), depth, st);
        errors++;
        return;
      end
      exp_rep = pending_reports.pop_front();
      if (top !== exp_rep.top) begin
        $error("top_value: expected %0d, got %0d", $signed(exp_rep.top), $signed(top));
        errors++;
      end
      if (depth !== exp_rep.depth) begin
        $error("stack_depth: expected %0d, got %0d", exp_rep.depth, depth);
        errors++;
      end
      if (st !== exp_rep.st) begin
        $error("status: expected %0d, got %0d", exp_rep.st, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  cmd_t               cmd;
  sword_t             operand_value;
  logic               done;
  sword_t             top_value;
  logic [DEPTH_W-1:0] stack_depth;
  status_t            status;

  stack_tracker tracker;
  int unsigned  cycle_count = 0;
  int unsigned  gen_depth;   // stimulus-side view of the depth, steers well-formed sequences
  bit           idle_on;

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .operand_value (operand_value),
    .done          (done),
    .top_value     (top_value),
    .stack_depth   (stack_depth),
    .status        (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Rising-edge monitor. Check first, then note: a result seen at the same edge
  // as an accepted token always belongs to an earlier token.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) tracker.check_report(word_t'(top_value), stack_depth, status);
      if (start && !busy) tracker.note_token(cmd, word_t'(operand_value));
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Value mix: extremes and small numbers often, so divides hit zero, +-1 and MIN.
  function automatic word_t pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return WORD_M1;
      3:       return WORD_MIN;
      4:       return WORD_MAX;
      5, 6:    return word_t'($urandom_range(0, 200)) - 32'd100;
      default: return $urandom;
    endcase
  endfunction

  // Offer one token beat at the falling edge; hold until taken at a rising edge
  // with busy low. Returns at the falling edge after the accept.
  task automatic send_token(input cmd_t c, input word_t v);
    while (idle_on && $urandom_range(0, 99) < 37) begin
      start         = 1'b0;
      cmd           = cmd_t'($urandom);
      operand_value = $urandom;
      @(negedge clk);
    end
    start         = 1'b1;
    cmd           = c;
    operand_value = v;
    do @(posedge clk); while (busy);
    @(negedge clk);
    case (c)
      CMD_PUSH:                           if (gen_depth < STACK_DEPTH) gen_depth++;
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
      CMD_CLEAR:                          gen_depth = 0;
      default: ;
    endcase
  endtask

  // Sender holds off until every queued report has come back.
  task automatic drain_reports();
    start = 1'b0;
    while (tracker.pending_reports.size() != 0) @(negedge clk);
  endtask

  initial begin
    int   roll;
    cmd_t op;
    tracker       = new();
    gen_depth     = 0;
    idle_on       = 1'b1;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = CMD_PUSH;
    operand_value = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed ----
    send_token(CMD_ADD,   $urandom);    // add on empty stack: operand missing
    send_token(CMD_CLEAR, $urandom);
    send_token(CMD_DIV,   $urandom);    // missing operand beats zero divisor
    send_token(CMD_CLEAR, $urandom);
    send_token(CMD_PUSH,  32'd7);
    send_token(CMD_DIV,   $urandom);    // one entry, nonzero divisor: still missing
    send_token(CMD_CLEAR, $urandom);
    send_token(CMD_PUSH,  WORD_MIN);
    send_token(CMD_PUSH,  WORD_M1);
    send_token(CMD_DIV,   $urandom);    // MIN / -1 wraps, status ok
    send_token(CMD_PUSH,  32'd5);
    send_token(CMD_PUSH,  '0);
    send_token(CMD_DIV,   $urandom);    // divide by zero
    send_token(CMD_PUSH,  WORD_MAX);
    send_token(CMD_PUSH,  32'd1);
    send_token(CMD_ADD,   $urandom);    // overflow wraps
    send_token(CMD_PUSH,  -32'sd7);
    send_token(CMD_PUSH,  32'd2);
    send_token(CMD_DIV,   $urandom);    // truncation toward zero: -3
    send_token(CMD_PUSH,  32'd3);
    send_token(CMD_SUB,   $urandom);    // left minus right
    send_token(CMD_PUSH,  WORD_MAX);
    send_token(CMD_MUL,   $urandom);    // product wraps
    send_token(CMD_SPARE_A, $urandom);
    send_token(CMD_SPARE_B, $urandom);

    drain_reports();

    // Fill to the limit, then push past it: dropped pushes report full.
    while (gen_depth < STACK_DEPTH) send_token(CMD_PUSH, pick_value());
    repeat ($urandom_range(1, 3)) send_token(CMD_PUSH, pick_value());

    // ---- random ----
    // Mostly well-formed expressions; ops on a short stack and spare codes as noise.
    for (int n = 0; n < 1000; n++) begin
      idle_on = !(n >= 350 && n < 550);   // long back-to-back stretch
      if (n == 700) drain_reports();
      roll = $urandom_range(0, 199);
      op   = cmd_t'($urandom_range(CMD_ADD, CMD_DIV));
      if (roll == 0) begin
        while (gen_depth < STACK_DEPTH) send_token(CMD_PUSH, pick_value());
        repeat ($urandom_range(1, 3)) send_token(CMD_PUSH, pick_value());
      end else if (gen_depth < 2 && roll >= 20) begin
        send_token(CMD_PUSH, pick_value());
      end else if (roll < 80 && gen_depth < 48) begin
        send_token(CMD_PUSH, pick_value());
      end else if (roll < 180) begin
        send_token(op, $urandom);
      end else if (roll < 192) begin
        send_token(CMD_CLEAR, $urandom);
      end else begin
        send_token($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B, $urandom);
      end
    end

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending_reports.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
